@@ hdl/sasu_pkg.sv @@
`timescale 1ns / 1ps

package sasu_pkg;

    // Array size and key width.
    localparam int DEPTH = 16;
    localparam int KEY_W = 32;

    // Derived widths: a slot index and a count that can hold DEPTH itself.
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [1:0]        t_status;

    // Result status codes.
    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_MISS = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    // Commands broadcast from the control logic to every cell.
    typedef struct packed {
        logic load_cmp;
        logic shift_up;
        logic shift_down;
    } t_cell_ctl;

endpackage

@@ hdl/sorted_array_set_update.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Fields
// request   in         i_valid / o_stall  i_mode, i_key
// result    out        o_valid / i_stall  o_status, o_slot, o_count
//
// Each item is handled in two steps: first every cell compares the key with
// its entry, then the cells shift together and the result is registered.
// A new item is taken only once the update step of the last one is done.
// Synchronous reset empties the set; cell contents are left as they are.
// A stalled result holds the update step until the output register is free.

module sorted_array_set_update import sasu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_key,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot,
    output logic [4:0]  o_count
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_mode;
    t_key    r_key;
    t_count  r_count;
    t_count  n_count;
    logic    r_out_valid;
    t_status r_out_status;
    t_status n_out_status;
    t_slot   r_out_slot;
    t_slot   n_out_slot;
    t_count  r_out_count;

    t_cell_ctl        cell_ctl;
    t_key             key_cmp;
    t_key [DEPTH-1:0] entry;
    logic [DEPTH-1:0] lt;
    logic [DEPTH-1:0] eq;
    logic [DEPTH-1:0] occupied;

    logic   accept;
    logic   update_go;
    logic   found;
    logic   full;
    logic   do_ins;
    logic   do_del;
    t_count pos;

    assign key_cmp   = i_key[KEY_W-1:0];
    assign accept    = i_valid && !o_stall;
    assign update_go = (r_state == S_UPDATE) && (!r_out_valid || !i_stall);

    // The compare results form a run of ones from slot zero; the slot is its length.
    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (lt[i]) begin
                pos = t_count'(i + 1);
            end
        end
    end

    assign found  = |eq;
    assign full   = (r_count == t_count'(DEPTH));
    assign do_ins = !r_mode && !found && !full;
    assign do_del = r_mode && found;

    assign cell_ctl.load_cmp   = accept;
    assign cell_ctl.shift_up   = update_go && do_ins;
    assign cell_ctl.shift_down = update_go && do_del;

    // Row of cells, each wired to its neighbors; the end cells take the held key in place of a missing one.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_key left_entry;
        logic left_lt;
        t_key right_entry;

        assign occupied[g] = (r_count > t_count'(g));

        if (g == 0) begin : g_first
            assign left_entry = r_key;
            assign left_lt    = 1'b1;
        end else begin : g_inner
            assign left_entry = entry[g-1];
            assign left_lt    = lt[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_entry = r_key;
        end else begin : g_next
            assign right_entry = entry[g+1];
        end

        sasu_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_occupied    (occupied[g]),
            .i_key_cmp     (key_cmp),
            .i_key_ins     (r_key),
            .i_left_entry  (left_entry),
            .i_left_lt     (left_lt),
            .i_right_entry (right_entry),
            .o_entry       (entry[g]),
            .o_lt          (lt[g]),
            .o_eq          (eq[g])
        );
    end

    // Next state, count and result fields.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (update_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + t_count'(1);
        end else if (do_del) begin
            n_count = r_count - t_count'(1);
        end

        n_out_slot = '0;
        if (do_ins || do_del) begin
            n_out_status = ST_DONE;
            n_out_slot   = pos[SLOT_W-1:0];
        end else if (!r_mode && !found) begin
            n_out_status = ST_FULL;
        end else begin
            n_out_status = ST_MISS;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (update_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_key  <= key_cmp;
        end
        if (update_go) begin
            r_out_status <= n_out_status;
            r_out_slot   <= n_out_slot;
            r_out_count  <= n_count;
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_slot   = r_out_slot;
    assign o_count  = r_out_count;

endmodule

@@ hdl/sasu_cell.sv @@
`timescale 1ns / 1ps

module sasu_cell import sasu_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  t_key      i_key_cmp,
    input  t_key      i_key_ins,
    input  t_key      i_left_entry,
    input  logic      i_left_lt,
    input  t_key      i_right_entry,
    output t_key      o_entry,
    output logic      o_lt,
    output logic      o_eq
);

    t_key r_entry;
    t_key n_entry;
    logic r_lt;
    logic r_eq;

    // Compare the incoming key against this cell's entry when an item is taken.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_cmp) begin
            r_lt <= i_occupied && (r_entry < i_key_cmp);
            r_eq <= i_occupied && (r_entry == i_key_cmp);
        end
    end

    // Cells holding smaller keys keep them; the rest shift toward or away
    // from the touched slot. The first cell whose left neighbor is smaller
    // takes the new key on an insert.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_up && !r_lt) begin
            n_entry = i_left_lt ? i_key_ins : i_left_entry;
        end else if (i_ctl.shift_down && !r_lt) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

@@ hdl/sasu_checker.sv @@
`timescale 1ns / 1ps

module sasu_checker import sasu_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [3:0]  o_slot,
    input logic [4:0]  o_count
);

    // No result is shown in the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result keeps its fields.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_slot)
            && $stable(o_count))
        else $error("stalled result changed");

    // Once an item is taken, the input stalls while the block updates.
    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after an item was taken");

    // An item that changed nothing reports slot zero.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DONE |-> o_slot == '0)
        else $error("nonzero slot on unchanged set");

    // Full is reported only with every slot in use.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_count == CNT_W'(DEPTH))
        else $error("full reported below capacity");

endmodule

bind sorted_array_set_update sasu_checker u_sasu_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_status (o_status),
    .o_slot   (o_slot),
    .o_count  (o_count)
);
